// File: rtl/core/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on clk, muted while rst is high.
`define CHK_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent check on clk that also runs during reset.
`define CHK_CLK_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/core/ttpt_pkg.sv
// Types, constants and stage records for the tape transport position tracker.
package ttpt_pkg;

  localparam int GAP_BYTES        = 275;
  localparam int BLOCK_DATA_BYTES = 1668;
  localparam int TRACK_END        = 740000;
  localparam int TAPE_START       = -14400;
  localparam int WARNING_MARGIN   = 3200;
  localparam int INIT_OFFSET      = 3000;
  localparam int INIT_POS         = TAPE_START + WARNING_MARGIN + INIT_OFFSET;
  localparam int PITCH            = GAP_BYTES + BLOCK_DATA_BYTES;

  localparam int SLOW_RESET = 16;
  localparam int FAST_RESET = 45;

  localparam int POS_W = 21;
  localparam int SPD_W = 8;
  localparam int TRK_W = 2;
  localparam int BLK_W = 9;
  localparam int OFF_W = 11;
  localparam int DIV_W = 20;

  localparam int RECIP_SHIFT = 30;
  localparam int RECIP_W     = 20;
  localparam int RECIP       = ((2 ** RECIP_SHIFT) + PITCH - 1) / PITCH;
  localparam int PROD_W      = DIV_W + RECIP_W;

  localparam int IN_W  = 8;
  localparam int OUT_W = 48;

  localparam int I_SF   = 0;
  localparam int I_FF   = 1;
  localparam int I_SR   = 2;
  localparam int I_FR   = 3;
  localparam int I_SEL  = 4;
  localparam int I_BUSY = 6;
  localparam int I_INIT = 7;

  localparam int O_AT_START = 1;
  localparam int O_START    = 6;
  localparam int O_CANCEL   = 7;
  localparam int O_LOAD     = 8;
  localparam int O_POS      = 20;

  typedef logic signed [POS_W-1:0] pos_t;
  typedef logic signed [POS_W:0]   pos_ext_t;

  typedef enum logic [2:0] {
    MODE_IDLE = 3'd0,
    MODE_SF   = 3'd1,
    MODE_FF   = 3'd2,
    MODE_SR   = 3'd3,
    MODE_FR   = 3'd4
  } mode_t;

  typedef enum logic {
    CFG_SLOW_RATE = 1'b0,
    CFG_FAST_RATE = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    mode_t            mode;
    logic             init;
    logic             busy;
    logic [TRK_W-1:0] sel;
    logic [TRK_W-1:0] trk_prev;
    logic [TRK_W-1:0] trk_used;
    pos_t             pos;
    logic             at_start;
    logic             at_end;
    logic             early;
  } st1_t;

  typedef struct packed {
    st1_t             base;
    logic [BLK_W-1:0] blk;
  } st2_t;

endpackage

// File: rtl/core/tape_transport_position_tracker.sv
// Top level of the tape transport position tracker.
// Stages in order: update, locate, emit; each holds its result in a register.
// Throughput: one beat per cycle while the result side accepts; the reciprocal multiply and offset path are pipelined.
// Backpressure on the result side stalls stages back to the input only when all are full.
// Reset: idle mode, position at tape start, read track 0, detect low, speeds 16 and 45,
// all stages empty.
module tape_transport_position_tracker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  // cmd_slow_forward, cmd_fast_forward, cmd_slow_reverse, cmd_fast_reverse,
  // read_track_select[1:0], transfer_busy, init_request
  input  logic [ttpt_pkg::IN_W-1:0]   s_axis_tdata,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // tape_moving, at_start, at_end, early_warning, detect flag, track_mismatch,
  // start_transfer, abort request, load_block_request, block_number[8:0],
  // read_track_used[1:0], byte position[20:0], zero fill
  output logic [ttpt_pkg::OUT_W-1:0]  m_axis_tdata,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic                        cfg_index,
  input  logic [ttpt_pkg::SPD_W-1:0]  cfg_data
);

  logic [ttpt_pkg::SPD_W-1:0] slow_rate;
  logic [ttpt_pkg::SPD_W-1:0] fast_rate;
  logic                       st1_valid;
  logic                       st1_ready;
  ttpt_pkg::st1_t             st1;
  logic                       st2_valid;
  logic                       st2_ready;
  ttpt_pkg::st2_t             st2;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      slow_rate <= ttpt_pkg::SPD_W'(ttpt_pkg::SLOW_RESET);
      fast_rate <= ttpt_pkg::SPD_W'(ttpt_pkg::FAST_RESET);
    end else if (cfg_valid && cfg_ready) begin
      case (ttpt_pkg::cfg_idx_t'(cfg_index))
        ttpt_pkg::CFG_SLOW_RATE: slow_rate <= cfg_data;
        ttpt_pkg::CFG_FAST_RATE: fast_rate <= cfg_data;
        default: slow_rate <= slow_rate;
      endcase
    end
  end

  ttpt_motion u_motion (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_data    (s_axis_tdata),
    .slow_rate  (slow_rate),
    .fast_rate  (fast_rate),
    .st1_valid  (st1_valid),
    .st1_ready  (st1_ready),
    .st1        (st1)
  );

  ttpt_locate u_locate (
    .clk       (clk),
    .rst       (rst),
    .st1_valid (st1_valid),
    .st1_ready (st1_ready),
    .st1       (st1),
    .st2_valid (st2_valid),
    .st2_ready (st2_ready),
    .st2       (st2)
  );

  ttpt_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .st2_valid (st2_valid),
    .st2_ready (st2_ready),
    .st2       (st2),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata)
  );

endmodule

// File: rtl/core/ttpt_motion.sv
// Motion mode decode, position update with clamping and read track latch.
module ttpt_motion (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [ttpt_pkg::IN_W-1:0]   in_data,
  input  logic [ttpt_pkg::SPD_W-1:0]  slow_rate,
  input  logic [ttpt_pkg::SPD_W-1:0]  fast_rate,
  output logic                        st1_valid,
  input  logic                        st1_ready,
  output ttpt_pkg::st1_t              st1
);

  ttpt_pkg::mode_t                motion_mode;
  ttpt_pkg::pos_t                 position;
  logic [ttpt_pkg::TRK_W-1:0]     latched_track;

  ttpt_pkg::mode_t                mode;
  logic                           init;
  logic                           busy;
  logic [ttpt_pkg::TRK_W-1:0]     sel;
  logic                           accept;
  logic [ttpt_pkg::SPD_W-1:0]     spd;
  logic                           rev;
  ttpt_pkg::pos_ext_t             delta;
  ttpt_pkg::pos_ext_t             moved;
  ttpt_pkg::pos_t                 clamped;
  ttpt_pkg::pos_t                 position_next;
  logic [ttpt_pkg::TRK_W-1:0]     track_next;

  assign init     = in_data[ttpt_pkg::I_INIT];
  assign busy     = in_data[ttpt_pkg::I_BUSY];
  assign sel      = in_data[ttpt_pkg::I_SEL +: ttpt_pkg::TRK_W];
  assign in_ready = !st1_valid || st1_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    if (in_data[ttpt_pkg::I_SF]) begin
      mode = ttpt_pkg::MODE_SF;
    end else if (in_data[ttpt_pkg::I_FF]) begin
      mode = ttpt_pkg::MODE_FF;
    end else if (in_data[ttpt_pkg::I_SR]) begin
      mode = ttpt_pkg::MODE_SR;
    end else if (in_data[ttpt_pkg::I_FR]) begin
      mode = ttpt_pkg::MODE_FR;
    end else begin
      mode = ttpt_pkg::MODE_IDLE;
    end

    spd = '0;
    rev = 1'b0;
    if (mode == motion_mode) begin
      case (mode)
        ttpt_pkg::MODE_SF: spd = slow_rate;
        ttpt_pkg::MODE_FF: spd = fast_rate;
        ttpt_pkg::MODE_SR: begin
          spd = slow_rate;
          rev = 1'b1;
        end
        ttpt_pkg::MODE_FR: begin
          spd = fast_rate;
          rev = 1'b1;
        end
        default: spd = '0;
      endcase
    end

    delta = ttpt_pkg::pos_ext_t'({1'b0, spd});
    if (rev) begin
      delta = -delta;
    end
    moved = ttpt_pkg::pos_ext_t'(position) + delta;

    if (moved <= ttpt_pkg::pos_ext_t'(ttpt_pkg::TAPE_START)) begin
      clamped = ttpt_pkg::pos_t'(ttpt_pkg::TAPE_START);
    end else if (moved >= ttpt_pkg::pos_ext_t'(ttpt_pkg::TRACK_END)) begin
      clamped = ttpt_pkg::pos_t'(ttpt_pkg::TRACK_END);
    end else begin
      clamped = moved[ttpt_pkg::POS_W-1:0];
    end

    position_next = init ? ttpt_pkg::pos_t'(ttpt_pkg::INIT_POS) : clamped;
    track_next    = (!init && !busy) ? sel : latched_track;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      motion_mode   <= ttpt_pkg::MODE_IDLE;
      position      <= ttpt_pkg::pos_t'(ttpt_pkg::TAPE_START);
      latched_track <= '0;
      st1_valid     <= 1'b0;
    end else begin
      if (accept) begin
        if (!init) begin
          motion_mode <= mode;
        end
        position      <= position_next;
        latched_track <= track_next;
        st1_valid     <= 1'b1;
      end else if (st1_ready) begin
        st1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      st1.mode     <= init ? ttpt_pkg::MODE_IDLE : mode;
      st1.init     <= init;
      st1.busy     <= busy;
      st1.sel      <= sel;
      st1.trk_prev <= latched_track;
      st1.trk_used <= track_next;
      st1.pos      <= position_next;
      st1.at_start <= position_next <= ttpt_pkg::pos_t'(ttpt_pkg::TAPE_START);
      st1.at_end   <= position_next >= ttpt_pkg::pos_t'(ttpt_pkg::TRACK_END);
      st1.early    <=
        (position_next <= ttpt_pkg::pos_t'(ttpt_pkg::TAPE_START + ttpt_pkg::WARNING_MARGIN)) ||
        (position_next >= ttpt_pkg::pos_t'(ttpt_pkg::TRACK_END - ttpt_pkg::WARNING_MARGIN));
    end
  end

endmodule

// File: rtl/core/ttpt_locate.sv
// Block number by reciprocal multiplication of the position.
module ttpt_locate (
  input  logic           clk,
  input  logic           rst,
  input  logic           st1_valid,
  output logic           st1_ready,
  input  ttpt_pkg::st1_t st1,
  output logic           st2_valid,
  input  logic           st2_ready,
  output ttpt_pkg::st2_t st2
);

  logic [ttpt_pkg::PROD_W-1:0] prod;
  logic [ttpt_pkg::BLK_W-1:0]  blk;
  logic                        adv;

  assign st1_ready = !st2_valid || st2_ready;
  assign adv       = st1_valid && st1_ready;

  assign prod = ttpt_pkg::PROD_W'(st1.pos[ttpt_pkg::DIV_W-1:0]) *
                ttpt_pkg::PROD_W'(ttpt_pkg::RECIP);
  assign blk  = st1.pos[ttpt_pkg::POS_W-1] ? '0 :
                prod[ttpt_pkg::RECIP_SHIFT +: ttpt_pkg::BLK_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      st2_valid <= 1'b0;
    end else if (adv) begin
      st2_valid <= 1'b1;
    end else if (st2_ready) begin
      st2_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st2.base <= st1;
      st2.blk  <= blk;
    end
  end

endmodule

// File: rtl/core/ttpt_emit.sv
// Intra-block offset, data detect line, transfer requests and result register.
module ttpt_emit (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         st2_valid,
  output logic                         st2_ready,
  input  ttpt_pkg::st2_t               st2,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [ttpt_pkg::OUT_W-1:0]   out_data
);

  logic                        detect_line;
  logic                        detect_line_next;
  logic [ttpt_pkg::DIV_W-1:0]  blk_bytes;
  logic [ttpt_pkg::DIV_W-1:0]  off_full;
  logic [ttpt_pkg::OFF_W-1:0]  off;
  logic                        past_gap;
  logic                        neg;
  logic                        moving;
  logic                        start;
  logic                        cancel;
  logic                        load;
  logic                        mismatch;
  logic                        adv;
  ttpt_pkg::st1_t              b;

  assign b         = st2.base;
  assign st2_ready = !out_valid || out_ready;
  assign adv       = st2_valid && st2_ready;
  assign neg       = b.pos[ttpt_pkg::POS_W-1];

  assign blk_bytes = ttpt_pkg::DIV_W'(st2.blk) * ttpt_pkg::DIV_W'(ttpt_pkg::PITCH);
  assign off_full  = b.pos[ttpt_pkg::DIV_W-1:0] - blk_bytes;
  assign off       = neg ? '0 : off_full[ttpt_pkg::OFF_W-1:0];
  assign past_gap  = off > ttpt_pkg::OFF_W'(ttpt_pkg::GAP_BYTES);

  always_comb begin
    detect_line_next = detect_line;
    if (b.init) begin
      detect_line_next = 1'b0;
    end else if (b.mode == ttpt_pkg::MODE_FF || b.mode == ttpt_pkg::MODE_SR ||
                 b.mode == ttpt_pkg::MODE_FR) begin
      detect_line_next = past_gap && ((st2.blk != '0) || (b.trk_prev == '0));
    end
    moving   = !b.init && (b.mode != ttpt_pkg::MODE_IDLE);
    start    = !b.init && (b.mode == ttpt_pkg::MODE_SF) && !b.busy && past_gap;
    cancel   = b.init || (b.mode != ttpt_pkg::MODE_SF);
    load     = b.init || (b.mode == ttpt_pkg::MODE_SF) || (b.mode == ttpt_pkg::MODE_IDLE);
    mismatch = b.sel != b.trk_used;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      detect_line <= 1'b0;
      out_valid   <= 1'b0;
    end else if (adv) begin
      detect_line <= detect_line_next;
      out_valid   <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data <= {7'b0, b.pos, b.trk_used, st2.blk, load, cancel, start, mismatch,
                   detect_line_next, b.early, b.at_end, b.at_start, moving};
    end
  end

endmodule

// File: rtl/core/ttpt_checker.sv
// Port-level checks for the tape transport position tracker, bound to the top level.
`include "assert_macros.svh"

module ttpt_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        m_axis_tvalid,
  input logic                        m_axis_tready,
  input logic [ttpt_pkg::OUT_W-1:0]  m_axis_tdata
);

  ttpt_pkg::pos_t out_pos;

  assign out_pos = m_axis_tdata[ttpt_pkg::O_POS +: ttpt_pkg::POS_W];

  `CHK_CLK(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "result beat changed while stalled")
  `CHK_CLK_ALWAYS(a_reset_empty, $past(rst) && !rst |-> !m_axis_tvalid, "result beat right after reset")
  `CHK_CLK(a_start_pos, m_axis_tvalid && m_axis_tdata[ttpt_pkg::O_AT_START] |-> out_pos == ttpt_pkg::pos_t'(ttpt_pkg::TAPE_START), "at_start without position at tape start")
  `CHK_CLK(a_cancel_load, m_axis_tvalid |-> m_axis_tdata[ttpt_pkg::O_CANCEL] || m_axis_tdata[ttpt_pkg::O_LOAD], "neither cancel nor load requested")
  `CHK_CLK(a_start_excl, m_axis_tvalid && m_axis_tdata[ttpt_pkg::O_START] |-> !m_axis_tdata[ttpt_pkg::O_CANCEL], "start and cancel in the same beat")

endmodule

bind tape_transport_position_tracker ttpt_checker u_ttpt_checker (.*);
